// ----- rtl/core/cfa_pkg.sv -----
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared constants, codes and types of the contiguous fit allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;

    // map geometry
    localparam int NUM_BLOCKS = 128;
    localparam int ADDR_W     = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

    // transaction field widths
    localparam int IDX_W      = 7;
    localparam int SIZE_W     = 8;
    localparam int STRAT_W    = 2;
    localparam int START_W    = 7;
    localparam int LEN_W      = 8;
    localparam int CMP_W      = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 16;

    localparam logic [CNT_W-1:0] MAP_END = CNT_W'(NUM_BLOCKS);

    // command codes (slave tuser)
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // fit strategies
    localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd0;
    localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd1;
    localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd2;
    localparam logic [STRAT_W-1:0] STRAT_NONE  = 2'd3;

    // map write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic              used;
    } t_map_wr;

    // allocation outcome
    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start_block;
        logic [LEN_W-1:0]   run_length;
    } t_result;

endpackage

// ----- rtl/core/cfa_map_mem.sv -----
// ----------------------------------------------------------------------------
// cfa_map_mem
// Block map storage: one bit per block, registered synchronous read,
// per-entry valid bits so that a block never written reads as free.
// ----------------------------------------------------------------------------
module cfa_map_mem
    import cfa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_map_wr           i_wr,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic              o_rd_used
);

    logic                  r_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_valid;
    logic                  r_rd_bit;
    logic                  r_rd_valid;

    // written marks, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // map array with registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.used;
        end
        if (i_rd_en) begin
            r_rd_bit   <= r_mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_used = r_rd_bit & r_rd_valid;

endmodule

// ----- rtl/core/cfa_scan.sv -----
// ----------------------------------------------------------------------------
// cfa_scan
// Walks the block map one entry per cycle, tracks the current free run and
// keeps the run chosen by the requested fit strategy.
// ----------------------------------------------------------------------------
module cfa_scan
    import cfa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SIZE_W-1:0]  i_size,
    input  logic [STRAT_W-1:0] i_strategy,
    output logic               o_idle,
    output logic               o_done,
    input  logic               i_done_ack,
    output t_result            o_result,
    output logic               o_rd_en,
    output logic [ADDR_W-1:0]  o_rd_addr,
    input  logic               i_rd_used
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_proc_vld;
    logic [CNT_W-1:0]    r_proc_pos;
    logic [SIZE_W-1:0]   r_size;
    logic [STRAT_W-1:0]  r_strat;
    logic [ADDR_W-1:0]   r_run_start;
    logic [CNT_W-1:0]    r_run_len;
    logic                r_have;
    logic [ADDR_W-1:0]   r_best_start;
    logic [CNT_W-1:0]    r_best_len;

    logic                scanning;
    logic                at_end;
    logic                is_free;
    logic                fits;
    logic                take;

    assign scanning = (r_state == ST_SCAN);
    assign at_end   = (r_proc_pos == MAP_END);
    assign is_free  = !at_end && !i_rd_used;
    assign fits     = (CMP_W'(r_run_len) >= CMP_W'(r_size));

    // selection rule for a closed run
    always_comb begin
        take = 1'b0;
        if (fits && (r_strat != STRAT_NONE)) begin
            priority if (!r_have) begin
                take = 1'b1;
            end else if (r_strat == STRAT_BEST) begin
                take = (r_run_len < r_best_len);
            end else if (r_strat == STRAT_WORST) begin
                take = (r_run_len > r_best_len);
            end else begin
                take = 1'b0;
            end
        end
    end

    // map read issue
    assign o_rd_en   = scanning && (r_cnt < MAP_END);
    assign o_rd_addr = r_cnt[ADDR_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_proc_vld && at_end) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_done_ack) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_proc_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_proc_vld <= scanning && !(r_proc_vld && at_end);
        end
    end

    // scan datapath
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_start) begin
            r_cnt       <= '0;
            r_proc_pos  <= '0;
            r_size      <= (i_size == '0) ? SIZE_W'(1) : i_size;
            r_strat     <= i_strategy;
            r_run_len   <= '0;
            r_run_start <= '0;
            r_have      <= 1'b0;
            r_best_start <= '0;
            r_best_len  <= '0;
        end else if (scanning) begin
            if (r_cnt != MAP_END) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            r_proc_pos <= r_cnt;
            if (r_proc_vld) begin
                if (is_free) begin
                    if (r_run_len == '0) begin
                        r_run_start <= r_proc_pos[ADDR_W-1:0];
                    end
                    r_run_len <= r_run_len + CNT_W'(1);
                end else begin
                    if (take) begin
                        r_have       <= 1'b1;
                        r_best_start <= r_run_start;
                        r_best_len   <= r_run_len;
                    end
                    r_run_len <= '0;
                end
            end
        end
    end

    assign o_idle               = (r_state == ST_IDLE);
    assign o_done               = (r_state == ST_DONE);
    assign o_result.found       = r_have;
    assign o_result.start_block = r_have ? START_W'(r_best_start) : '0;
    assign o_result.run_length  = r_have ? LEN_W'(r_best_len) : '0;

endmodule

// ----- rtl/core/contiguous_fit_allocator.sv -----
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// Contiguous free-run allocator over a block map with first, best and worst
// fit, built around a one-bit-wide map memory that a scanner walks.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata fields (low bit up)                 | tuser
//  s_axis   | in  | block_index, block_used, request_size,    | command
//           |     | strategy                                  |
//  m_axis   | out | start_block, run_length                   | found
//
// A map write gives no result transaction.
// For an allocation request the scanner reads one
// map entry per cycle through the single read port of the map memory.
// Reset clears the map to all free at once through per-entry valid bits.
// A result waiting on m_axis does not block the next s_axis transaction; a
// finished scan holds until the output register is free.
// ----------------------------------------------------------------------------
module contiguous_fit_allocator
    import cfa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // block_index[6:0], block_used[7], request_size[15:8], strategy[17:16]
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    // command[0]
    input  logic                i_s_axis_tuser,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // start_block[6:0], run_length[14:7]
    output logic [M_DATA_W-1:0] o_m_axis_tdata,
    // found[0]
    output logic                o_m_axis_tuser
);

    logic               s_fire;
    logic [IDX_W-1:0]   in_index;
    logic               in_used;
    logic [SIZE_W-1:0]  in_size;
    logic [STRAT_W-1:0] in_strat;
    t_map_wr            map_wr;
    logic               scan_idle;
    logic               scan_done;
    logic               scan_ack;
    t_result            scan_result;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               rd_used;
    logic               r_out_valid;
    t_result            r_out;

    // input unpacking
    assign in_index = i_s_axis_tdata[IDX_W-1:0];
    assign in_used  = i_s_axis_tdata[IDX_W];
    assign in_size  = i_s_axis_tdata[IDX_W+1 +: SIZE_W];
    assign in_strat = i_s_axis_tdata[IDX_W+1+SIZE_W +: STRAT_W];

    assign o_s_axis_tready = scan_idle;
    assign s_fire          = i_s_axis_tvalid && scan_idle;

    // map write from a write transaction, out-of-range index dropped
    assign map_wr.en   = s_fire && (i_s_axis_tuser == CMD_WRITE)
                         && (32'(in_index) < NUM_BLOCKS);
    assign map_wr.addr = ADDR_W'(in_index);
    assign map_wr.used = in_used;

    cfa_map_mem u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (map_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_used (rd_used)
    );

    cfa_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_fire && (i_s_axis_tuser == CMD_ALLOC)),
        .i_size     (in_size),
        .i_strategy (in_strat),
        .o_idle     (scan_idle),
        .o_done     (scan_done),
        .i_done_ack (scan_ack),
        .o_result   (scan_result),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_used  (rd_used)
    );

    // output register handoff
    assign scan_ack = scan_done && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (scan_ack) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_ack) begin
            r_out <= scan_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.found;
    assign o_m_axis_tdata  = {1'b0, r_out.run_length, r_out.start_block};

endmodule

// ----- bench/alloc_checker.sv -----
// ----------------------------------------------------------------------------
// alloc_checker
// Watches both stream channels of the contiguous fit allocator. It keeps a
// shadow block map, predicts the chosen free run for every allocation
// request and compares each result transaction field by field, in order.
// ----------------------------------------------------------------------------
module alloc_checker
    import cfa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    input  logic                i_s_axis_tready,
    // block_index[6:0], block_used[7], request_size[15:8], strategy[17:16]
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    // command[0]
    input  logic                i_s_axis_tuser,
    input  logic                i_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // start_block[6:0], run_length[14:7]
    input  logic [M_DATA_W-1:0] i_m_axis_tdata,
    // found[0]
    input  logic                i_m_axis_tuser,
    output int                  o_fail_count = 0,
    output int                  o_pending = 0
);
    timeunit 1ns;
    timeprecision 1ps;

    bit      shadow_map [NUM_BLOCKS];
    t_result expected_fits [$];
    int      fails = 0;

    // scan the shadow map for maximal free runs and pick one by strategy
    function automatic t_result pick_free_run(input logic [SIZE_W-1:0] size_req,
                                              input logic [STRAT_W-1:0] strat);
        t_result     pick;
        int unsigned need;
        int unsigned run_start;
        int unsigned run_len;
        int unsigned best_start;
        int unsigned best_len;
        bit          have;
        bit          take;
        pick       = '0;
        need       = (size_req == '0) ? 1 : size_req;
        run_start  = 0;
        run_len    = 0;
        best_start = 0;
        best_len   = 0;
        have       = 1'b0;
        if (strat != STRAT_NONE) begin
            // the extra pass past the last block closes a run at the map end
            for (int i = 0; i <= NUM_BLOCKS; i++) begin
                if (i < NUM_BLOCKS && !shadow_map[i]) begin
                    if (run_len == 0) run_start = i;
                    run_len++;
                end else begin
                    if (run_len != 0 && run_len >= need) begin
                        if (!have) take = 1'b1;
                        else if (strat == STRAT_BEST) take = run_len < best_len;
                        else if (strat == STRAT_WORST) take = run_len > best_len;
                        else take = 1'b0;
                        if (take) begin
                            have       = 1'b1;
                            best_start = run_start;
                            best_len   = run_len;
                        end
                    end
                    run_len = 0;
                end
            end
        end
        if (have) begin
            pick.found       = 1'b1;
            pick.start_block = START_W'(best_start);
            pick.run_length  = LEN_W'(best_len);
        end
        return pick;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    // result side first, then the incoming transaction
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            foreach (shadow_map[i]) shadow_map[i] = 1'b0;
            expected_fits.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.found       = i_m_axis_tuser;
                got.start_block = i_m_axis_tdata[START_W-1:0];
                got.run_length  = i_m_axis_tdata[START_W +: LEN_W];
                if (expected_fits.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %0d/%0d/%0d",
                             $time, got.found, got.start_block, got.run_length);
                    fails++;
                end else begin
                    want = expected_fits.pop_front();
                    check_field("found", want.found, got.found);
                    check_field("start_block", want.start_block, got.start_block);
                    check_field("run_length", want.run_length, got.run_length);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                if (i_s_axis_tuser == CMD_WRITE) begin
                    if (i_s_axis_tdata[IDX_W-1:0] < NUM_BLOCKS)
                        shadow_map[i_s_axis_tdata[IDX_W-1:0]] = i_s_axis_tdata[IDX_W];
                end else begin
                    expected_fits.push_back(pick_free_run(
                        i_s_axis_tdata[IDX_W+1 +: SIZE_W],
                        i_s_axis_tdata[IDX_W+1+SIZE_W +: STRAT_W]));
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_fits.size();
    end

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the contiguous fit allocator. A directed part
// covers the empty map, zero, full and oversized requests, ties and the
// unused strategy; random episodes then shape the map by scattered and
// ranged writes and follow them with requests. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfa_pkg::*;

    localparam int N_ITEMS     = 1850;
    localparam int IDLE_PCT    = 19;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = NUM_BLOCKS + 16;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [S_DATA_W-1:0] s_data  = '0;
    logic                s_user  = CMD_WRITE;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [M_DATA_W-1:0] m_data;
    logic                m_user;
    int                  fail_count;
    int                  pending;

    bit                  calm = 1'b0;
    int                  quiet = 0;
    int                  n_sent = 0;
    int                  n_writes = 0;
    int                  n_req [4] = '{0, 0, 0, 0};

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    contiguous_fit_allocator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    alloc_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_m_axis_tuser  (m_user),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // result side backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) m_ready <= 1'b0;
        else m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // one command transaction, with an optional random gap ahead of it
    task automatic send_item(input logic cmd, input logic [S_DATA_W-1:0] data);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
        s_valid <= 1'b1;
        s_data  <= data;
        s_user  <= cmd;
        do @(posedge i_clk); while (!s_ready);
        n_sent++;
        calm <= (n_sent >= 700) && (n_sent < 1000);
    endtask

    task automatic write_entry(input logic [IDX_W-1:0] idx, input logic used);
        n_writes++;
        send_item(CMD_WRITE, S_DATA_W'({used, idx}));
    endtask

    task automatic request_fit(input logic [SIZE_W-1:0] size_req,
                               input logic [STRAT_W-1:0] strat);
        n_req[strat]++;
        send_item(CMD_ALLOC, S_DATA_W'({strat, size_req, 1'b0, {IDX_W{1'b0}}}));
    endtask

    initial begin
        int unsigned used_pct;
        int unsigned base;
        int unsigned n;
        logic        val;
        logic [SIZE_W-1:0]  size_req;
        logic [STRAT_W-1:0] strat;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty map: whole-map, zero-size, oversized and unused strategy
        request_fit(8'd128, STRAT_FIRST);
        request_fit(8'd0, STRAT_BEST);
        request_fit(8'd129, STRAT_WORST);
        request_fit(8'd255, STRAT_FIRST);
        request_fit(8'd1, STRAT_NONE);
        // equal runs of nine and one long tail run
        write_entry(7'd0, 1'b1);
        write_entry(7'd127, 1'b1);
        write_entry(7'd10, 1'b1);
        write_entry(7'd20, 1'b1);
        write_entry(7'd30, 1'b1);
        request_fit(8'd9, STRAT_BEST);
        request_fit(8'd9, STRAT_WORST);
        request_fit(8'd9, STRAT_FIRST);
        request_fit(8'd96, STRAT_FIRST);
        request_fit(8'd97, STRAT_WORST);
        write_entry(7'd64, 1'b1);
        request_fit(8'd40, STRAT_BEST);
        // freeing merges runs, including the one at the map end
        write_entry(7'd10, 1'b0);
        request_fit(8'd10, STRAT_BEST);
        write_entry(7'd127, 1'b0);
        request_fit(8'd62, STRAT_WORST);
        request_fit(8'd1, STRAT_NONE);

        // hold off until the directed results are all back
        s_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);

        // random episodes: shape the map, then ask for runs
        while (n_sent < N_ITEMS) begin
            case ($urandom_range(0, 4))
                0:       used_pct = 0;
                1:       used_pct = 10;
                2:       used_pct = 50;
                3:       used_pct = 90;
                default: used_pct = 100;
            endcase
            if ($urandom_range(0, 2) == 0) begin
                base = $urandom_range(0, NUM_BLOCKS - 1);
                n    = $urandom_range(1, 40);
                val  = ($urandom_range(0, 99) < used_pct);
                for (int k = 0; k < n; k++) write_entry(IDX_W'(base + k), val);
            end else begin
                n = $urandom_range(1, 12);
                for (int k = 0; k < n; k++)
                    write_entry(IDX_W'($urandom_range(0, NUM_BLOCKS - 1)),
                                $urandom_range(0, 99) < used_pct);
            end
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: size_req = SIZE_W'($urandom_range(1, 8));
                    6, 7:             size_req = SIZE_W'($urandom_range(1, 64));
                    8:                size_req = SIZE_W'($urandom_range(0, 255));
                    default:          size_req = SIZE_W'($urandom_range(100, 128));
                endcase
                if ($urandom_range(0, 15) == 0) strat = STRAT_NONE;
                else strat = STRAT_W'($urandom_range(0, 2));
                request_fit(size_req, strat);
            end
        end

        // drain and let the scanner settle
        s_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d map writes and %0d requests", n_writes,
                 n_req[0] + n_req[1] + n_req[2] + n_req[3]);
        $display("requests by strategy: first %0d, best %0d, worst %0d, unused %0d",
                 n_req[0], n_req[1], n_req[2], n_req[3]);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/cfa_pkg.sv
rtl/core/cfa_map_mem.sv
rtl/core/cfa_scan.sv
rtl/core/contiguous_fit_allocator.sv
bench/alloc_checker.sv
bench/tb.sv
